[design/esc_pkg.sv]
// Shared types and constants for the CAN status decoder.
`default_nettype none
package esc_pkg;

  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned ID_W      = 29;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ARM   = 2'd3;

  localparam logic [7:0] CODE_RPM      = 8'd9;
  localparam logic [7:0] CODE_AH       = 8'd14;
  localparam logic [7:0] CODE_WH       = 8'd15;
  localparam logic [7:0] CODE_TEMP_POS = 8'd16;
  localparam logic [7:0] CODE_TACHO    = 8'd27;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_RPM      = 3'd1;
  localparam logic [2:0] KIND_AH       = 3'd2;
  localparam logic [2:0] KIND_WH       = 3'd3;
  localparam logic [2:0] KIND_TEMP_POS = 3'd4;
  localparam logic [2:0] KIND_TACHO    = 3'd5;

  localparam logic [5:0] ZERO_FRAME_COUNT = 6'd50;
  localparam logic [5:0] FRAMES_CAP       = 6'd51;

  localparam logic signed [23:0] TURN_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] TURN_MIN = -24'sh800000;
  localparam logic signed [15:0] COUNTS_PER_TURN = 16'sd18000;
  localparam logic signed [15:0] LOW_QUARTER     = 16'sd4500;
  localparam logic signed [15:0] HIGH_QUARTER    = 16'sd13500;
  localparam logic signed [35:0] SPEED_MAX = {1'b0, {35{1'b1}}};
  localparam logic signed [35:0] SPEED_MIN = {1'b1, {35{1'b0}}};

  localparam int unsigned DIV_W          = 36;
  localparam int unsigned DIV_BITS_CYCLE = 6;
  localparam int unsigned DIV_CYCLES     = DIV_W / DIV_BITS_CYCLE;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_CYCLES);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_FRAME,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [2:0]           kind;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [7:0] motor_id;
    logic       reverse;
    logic [7:0] pole_pairs;
    logic       zero_arm;
  } cfg_t;

endpackage
`default_nettype wire

[design/esc_front.sv]
// Front end: filters received frames by id and classifies the status kind.
`default_nettype none
module esc_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [esc_pkg::ID_W-1:0]      ext_id,
  input  wire logic                          is_extended,
  input  wire logic [esc_pkg::PAYLOAD_W-1:0] payload,
  input  wire logic [7:0]                    motor_id,
  input  wire logic                          q_full,
  output logic                               push,
  output esc_pkg::entry_t                    entry
);
  import esc_pkg::*;

  logic keep;
  logic [2:0] kind;

  always_comb begin
    unique case (ext_id[15:8])
      CODE_RPM:      kind = KIND_RPM;
      CODE_AH:       kind = KIND_AH;
      CODE_WH:       kind = KIND_WH;
      CODE_TEMP_POS: kind = KIND_TEMP_POS;
      CODE_TACHO:    kind = KIND_TACHO;
      default:       kind = KIND_NONE;
    endcase
  end

  assign keep     = action || (is_extended && (ext_id[7:0] == motor_id));
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && keep;

  assign entry.op      = action ? OP_ZERO : OP_FRAME;
  assign entry.kind    = kind;
  assign entry.payload = payload;

endmodule
`default_nettype wire

[design/esc_queue.sv]
// Short register queue between the front end and the execution back end.
`default_nettype none
module esc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire esc_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output esc_pkg::entry_t      head
);
  import esc_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[design/esc_back.sv]
// Back end: position tracking, speed division, auto-zero and result register.
`default_nettype none
module esc_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire esc_pkg::cfg_t         cfg,
  input  wire logic                  head_valid,
  input  wire esc_pkg::entry_t       head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 status_kind,
  output logic signed [31:0]         field_a,
  output logic signed [31:0]         field_b,
  output logic signed [15:0]         field_c,
  output logic signed [15:0]         single_turn_pos,
  output logic signed [23:0]         turn_count,
  output logic signed [39:0]         multi_turn_angle,
  output logic signed [35:0]         velocity_q4,
  output logic                       zeroed
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TURN,
    ST_MUL,
    ST_ANGLE,
    ST_EMIT
  } state_t;

  state_t state;

  logic signed [15:0]     last_pos;
  logic signed [23:0]     turns;
  logic signed [15:0]     zero_pos;
  logic signed [39:0]     angle_reg;
  logic signed [35:0]     speed_reg;
  logic [5:0]             frames_seen;

  logic [2:0]             cur_kind;
  logic [PAYLOAD_W-1:0]   cur_payload;
  logic                   fire;
  logic [7:0]             div_rem;
  logic [DIV_W-1:0]       div_work;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic                   div_neg;
  logic signed [39:0]     prod;

  logic [7:0]             rem_next;
  logic [DIV_W-1:0]       work_next;
  logic signed [36:0]     quot_signed;
  logic signed [35:0]     fa_x16;
  logic [DIV_W-1:0]       fa_abs;
  logic                   fresh;
  logic [5:0]             frames_next;
  logic signed [15:0]     new_pos;
  logic signed [39:0]     angle_sum;
  logic signed [31:0]     res_a;
  logic signed [31:0]     res_b;
  logic signed [15:0]     res_c;

  assign pop = (state == ST_IDLE) && head_valid;

  assign fa_x16      = {head.payload[63:32], 4'b0000};
  assign fa_abs      = head.payload[63] ? (DIV_W'(0) - DIV_W'(fa_x16)) : DIV_W'(fa_x16);
  assign fresh       = frames_seen < FRAMES_CAP;
  assign frames_next = fresh ? frames_seen + 6'd1 : frames_seen;
  assign new_pos     = cur_payload[15:0];
  assign angle_sum   = prod + 40'(last_pos) - 40'(zero_pos);

  always_comb begin
    logic [8:0] trial;
    rem_next  = div_rem;
    work_next = div_work;
    for (int i = 0; i < DIV_BITS_CYCLE; i++) begin
      trial     = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, cfg.pole_pairs}) begin
        trial        = trial - {1'b0, cfg.pole_pairs};
        work_next[0] = 1'b1;
      end
      rem_next = trial[7:0];
    end
    quot_signed = div_neg ? (37'sd0 - $signed({1'b0, work_next}))
                          : $signed({1'b0, work_next});
  end

  always_comb begin
    res_a = '0;
    res_b = '0;
    res_c = '0;
    unique case (cur_kind)
      KIND_RPM: begin
        res_a = cur_payload[63:32];
        res_b = 32'($signed(cur_payload[31:16]));
        res_c = cur_payload[15:0];
      end
      KIND_AH, KIND_WH: begin
        res_a = cur_payload[63:32];
        res_b = cur_payload[31:0];
      end
      KIND_TEMP_POS: begin
        res_a = 32'($signed(cur_payload[63:48]));
        res_b = 32'($signed(cur_payload[47:32]));
        res_c = cur_payload[31:16];
      end
      KIND_TACHO: begin
        res_a = cur_payload[63:32];
        res_b = 32'($signed(cur_payload[31:16]));
      end
      default: begin
        res_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      last_pos    <= '0;
      turns       <= '0;
      zero_pos    <= '0;
      angle_reg   <= '0;
      speed_reg   <= '0;
      frames_seen <= '0;
      fire        <= 1'b0;
    end else begin
      if (out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            cur_kind    <= head.kind;
            cur_payload <= head.payload;
            if (head.op == OP_ZERO) begin
              turns     <= '0;
              zero_pos  <= last_pos;
              angle_reg <= '0;
            end else begin
              frames_seen <= frames_next;
              fire        <= (head.kind != KIND_NONE) && fresh &&
                             (frames_next == ZERO_FRAME_COUNT) && cfg.zero_arm;
              div_rem     <= '0;
              div_work    <= fa_abs;
              div_cnt     <= '0;
              div_neg     <= head.payload[63] ^ cfg.reverse;
              unique case (head.kind)
                KIND_RPM:      state <= ST_DIV;
                KIND_TEMP_POS: state <= ST_TURN;
                default:       state <= ST_EMIT;
              endcase
            end
          end
        end
        ST_DIV: begin
          div_rem  <= rem_next;
          div_work <= work_next;
          div_cnt  <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            if (quot_signed > 37'(SPEED_MAX)) begin
              speed_reg <= SPEED_MAX;
            end else if (quot_signed < 37'(SPEED_MIN)) begin
              speed_reg <= SPEED_MIN;
            end else begin
              speed_reg <= quot_signed[35:0];
            end
            state <= ST_EMIT;
          end
        end
        ST_TURN: begin
          if (new_pos < LOW_QUARTER && last_pos > HIGH_QUARTER) begin
            if (turns < TURN_MAX) begin
              turns <= turns + 24'sd1;
            end
          end else if (new_pos > HIGH_QUARTER && last_pos < LOW_QUARTER) begin
            if (turns > TURN_MIN) begin
              turns <= turns - 24'sd1;
            end
          end
          last_pos <= new_pos;
          state    <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= turns * COUNTS_PER_TURN;
          state <= ST_ANGLE;
        end
        ST_ANGLE: begin
          angle_reg <= cfg.reverse ? (40'sd0 - angle_sum) : angle_sum;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            if (fire) begin
              turns     <= '0;
              zero_pos  <= last_pos;
              angle_reg <= '0;
            end
            out_valid        <= 1'b1;
            status_kind      <= cur_kind;
            field_a          <= res_a;
            field_b          <= res_b;
            field_c          <= res_c;
            single_turn_pos  <= last_pos;
            turn_count       <= fire ? 24'sd0 : turns;
            multi_turn_angle <= fire ? 40'sd0 : angle_reg;
            velocity_q4      <= speed_reg;
            zeroed           <= fire;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/esc_can_status_decoder_top.sv]
// Top level: configuration registers, front end, queue and back end.
// Path from input accept to result valid: through the queue, then the back end goes straight to the
// result register for kinds 2, 3, 5 and unknown kinds, through turn update, multiply and angle for kind 4,
// and through the radix-64 divider for kind 1. The back end takes a new item only when idle;
// a two-entry queue lets the input side keep accepting while the back end works.
// Reset (rst, synchronous): configuration to defaults, tracking state, queue and output.
`default_nettype none
module esc_can_status_decoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [esc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [esc_pkg::ID_W-1:0]      ext_id,
  input  wire logic                          is_extended,
  input  wire logic [esc_pkg::PAYLOAD_W-1:0] payload,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         status_kind,
  output logic signed [31:0]                 field_a,
  output logic signed [31:0]                 field_b,
  output logic signed [15:0]                 field_c,
  output logic signed [15:0]                 single_turn_pos,
  output logic signed [23:0]                 turn_count,
  output logic signed [39:0]                 multi_turn_angle,
  output logic signed [35:0]                 velocity_q4,
  output logic                               zeroed
);
  import esc_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   q_full;
  logic   head_valid;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motor_id   <= 8'd0;
      cfg.reverse    <= 1'b0;
      cfg.pole_pairs <= 8'd1;
      cfg.zero_arm   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOTOR_ID:   cfg.motor_id   <= cfg_data;
        CFG_REVERSE:    cfg.reverse    <= cfg_data[0];
        CFG_POLE_PAIRS: cfg.pole_pairs <= (cfg_data == 8'd0) ? 8'd1 : cfg_data;
        CFG_ZERO_ARM:   cfg.zero_arm   <= cfg_data[0];
        default:        cfg.zero_arm   <= cfg.zero_arm;
      endcase
    end
  end

  esc_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .ext_id      (ext_id),
    .is_extended (is_extended),
    .payload     (payload),
    .motor_id    (cfg.motor_id),
    .q_full      (q_full),
    .push        (push),
    .entry       (push_entry)
  );

  esc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  esc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status_kind      (status_kind),
    .field_a          (field_a),
    .field_b          (field_b),
    .field_c          (field_c),
    .single_turn_pos  (single_turn_pos),
    .turn_count       (turn_count),
    .multi_turn_angle (multi_turn_angle),
    .velocity_q4      (velocity_q4),
    .zeroed           (zeroed)
  );

endmodule
`default_nettype wire
